// ----- src/sswr_pkg.sv -----
// shared types and constants for the successive-approximation search with window refine
package sswr_pkg;

	localparam int CODE_W     = 8;
	localparam int WORD_WIDTH = 32;
	localparam int COL_W      = 5;
	localparam int HALF_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int BIT_IDX_W  = 3;

	localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(255);

	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_SELECT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_POLICY = 2'd2;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_READOUT = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [WORD_WIDTH-1:0] readout_word;
	} in_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              done_res;
	} out_t;

endpackage

// ----- src/sar_search_with_window_refine_top.sv -----
// Use of the block:
// A start request (action 0) opens an 8-step binary search on one comparator
// bit of the readout word, picked by column_select. Every readout (action 1)
// after that yields the next trial code to drive, and finally the result code
// with done_res set. After the binary search a linear sweep runs over a
// window of window_half around the search result, with a full sweep of codes
// 0 to 254 as fallback if the window finds no hit, but not under policy 1 with result 0.
// Input and output are valid/ready channels; each accepted input gives one
// result. The result is held in the single output register and appears in the
// cycle after the input transfer; a new input can be taken every cycle while
// the receiver does not stall the output.
// A new input is taken when the output register is empty or drained in the
// same cycle, so a stalled receiver stalls the input side after one item.
// Configuration writes take effect at the clock edge of the write.
// Reset clears the search state, returns the registers to their defaults
// (column 0, half width 8, policy 0) and empties the output register.
module sar_search_with_window_refine_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sswr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sswr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sswr_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sswr_pkg::out_t                     out_data
);
	import sswr_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SAR  = 2'd1;
	localparam logic [1:0] PH_WIN  = 2'd2;
	localparam logic [1:0] PH_FULL = 2'd3;

	logic [COL_W-1:0]     column_select_q;
	logic [HALF_W-1:0]    window_half_q;
	logic                 fallback_policy_q;

	logic [1:0]           phase_q, phase_d;
	logic [BIT_IDX_W-1:0] bit_index_q, bit_index_d;
	logic [CODE_W-1:0]    approx_value_q, approx_value_d;
	logic [CODE_W-1:0]    search_start_q, search_start_d;
	logic [CODE_W-1:0]    sweep_code_q, sweep_code_d;
	logic [CODE_W-1:0]    sweep_limit_q, sweep_limit_d;
	logic [CODE_W-1:0]    last_hit_q, last_hit_d;

	logic                 out_valid_q;
	out_t                 out_data_q, res_d;

	logic                 accept;
	logic                 hit;
	logic [CODE_W-1:0]    trial;
	logic [CODE_W-1:0]    approx_new;
	logic [CODE_W-1:0]    win_lo;
	logic [CODE_W:0]      win_sum;
	logic [CODE_W-1:0]    win_hi;
	logic [CODE_W:0]      sweep_next;
	logic                 fallback;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_select_q   <= '0;
			window_half_q     <= HALF_W'(8);
			fallback_policy_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMN_SELECT:   column_select_q   <= cfg_data[COL_W-1:0];
				REG_WINDOW_HALF:     window_half_q     <= cfg_data[HALF_W-1:0];
				REG_FALLBACK_POLICY: fallback_policy_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// comparator bit and the window bounds around the fresh search result
	always_comb begin
		hit        = in_data.readout_word[column_select_q];
		trial      = approx_value_q | (CODE_W'(1) << bit_index_q);
		approx_new = hit ? trial : approx_value_q;
		win_lo     = (approx_new > window_half_q) ? approx_new - window_half_q : '0;
		win_sum    = {1'b0, approx_new} + {1'b0, window_half_q};
		win_hi     = (win_sum > {1'b0, CODE_MAX}) ? CODE_MAX : win_sum[CODE_W-1:0];
		sweep_next = {1'b0, sweep_code_q} + (CODE_W+1)'(1);
	end

	always_comb begin
		phase_d        = phase_q;
		bit_index_d    = bit_index_q;
		approx_value_d = approx_value_q;
		search_start_d = search_start_q;
		sweep_code_d   = sweep_code_q;
		sweep_limit_d  = sweep_limit_q;
		last_hit_d     = last_hit_q;
		res_d.code     = last_hit_q;
		res_d.done_res = 1'b1;
		fallback       = 1'b0;

		if (in_data.action == ACT_START) begin
			phase_d        = PH_SAR;
			bit_index_d    = BIT_IDX_W'(7);
			approx_value_d = '0;
			res_d.code     = CODE_W'(1) << 7;
			res_d.done_res = 1'b0;
		end else begin
			unique case (phase_q)
				PH_SAR: begin
					approx_value_d = approx_new;
					if (bit_index_q != '0) begin
						bit_index_d    = bit_index_q - BIT_IDX_W'(1);
						res_d.code     = approx_new | (CODE_W'(1) << bit_index_d);
						res_d.done_res = 1'b0;
					end else begin
						bit_index_d    = BIT_IDX_W'(7);
						search_start_d = approx_new;
						if (win_lo < win_hi) begin
							phase_d        = PH_WIN;
							sweep_code_d   = win_lo;
							sweep_limit_d  = win_hi;
							last_hit_d     = '0;
							res_d.code     = win_lo;
							res_d.done_res = 1'b0;
						end else begin
							// empty window counts as no hit
							last_hit_d = '0;
							fallback   = !fallback_policy_q || (approx_new != '0);
							if (!fallback) begin
								phase_d    = PH_IDLE;
								res_d.code = '0;
							end
						end
					end
				end
				PH_WIN, PH_FULL: begin
					if (hit) begin
						last_hit_d = sweep_code_q;
					end
					sweep_code_d = sweep_next[CODE_W-1:0];
					if (sweep_next < {1'b0, sweep_limit_q}) begin
						res_d.code     = sweep_next[CODE_W-1:0];
						res_d.done_res = 1'b0;
					end else begin
						fallback = (phase_q == PH_WIN) && (last_hit_d == '0)
							&& (!fallback_policy_q || (search_start_q != '0));
						if (!fallback) begin
							phase_d    = PH_IDLE;
							res_d.code = last_hit_d;
						end
					end
				end
				default: ;
			endcase
		end

		// full sweep over 0 .. CODE_MAX-1
		if (fallback) begin
			phase_d        = PH_FULL;
			sweep_code_d   = '0;
			sweep_limit_d  = CODE_MAX;
			last_hit_d     = '0;
			res_d.code     = '0;
			res_d.done_res = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_index_q    <= BIT_IDX_W'(7);
			approx_value_q <= '0;
			search_start_q <= '0;
			sweep_code_q   <= '0;
			sweep_limit_q  <= '0;
			last_hit_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				phase_q        <= phase_d;
				bit_index_q    <= bit_index_d;
				approx_value_q <= approx_value_d;
				search_start_q <= search_start_d;
				sweep_code_q   <= sweep_code_d;
				sweep_limit_q  <= sweep_limit_d;
				last_hit_q     <= last_hit_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res_d;
		end
	end

endmodule

// ----- tb/sar_search_with_window_refine_top_test.sv -----
// self-checking testbench for the successive-approximation search with window refine
`timescale 1ns / 100ps

module sar_search_with_window_refine_top_test;
	import sswr_pkg::*;

	localparam int ITEM_TARGET  = 750;
	localparam int RANDOM_ITEMS = 650;
	localparam int STUCK_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	typedef enum logic [1:0] {SRCH_IDLE, SRCH_SAR, SRCH_WINDOW, SRCH_FULL} search_phase_t;
	typedef enum logic [1:0] {HITS_BELOW_TARGET, HITS_RANDOM, HITS_NONE} hit_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;

	// predictor copy of the search state and the registers
	search_phase_t   phase_q;
	logic [2:0]      bit_pos;
	logic [7:0]      approx;
	logic [7:0]      start_code;
	logic [7:0]      sweep_at;
	logic [7:0]      sweep_end;
	logic [7:0]      best_hit;
	logic [COL_W-1:0] col_sel;
	logic [7:0]      half_width;
	logic            policy_q;

	out_t expected_results[$];
	out_t oldest;
	int   items_sent;
	int   failures;
	int   stuck_cycles;
	bit   gaps_on;

	sar_search_with_window_refine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic out_t make_result(input logic [7:0] code, input logic done);
		out_t r;
		r.code     = code;
		r.done_res = done;
		return r;
	endfunction

	function automatic out_t open_sweep(input search_phase_t ph, input logic [7:0] lo,
			input logic [7:0] hi);
		phase_q   = ph;
		sweep_at  = lo;
		sweep_end = hi;
		best_hit  = 8'd0;
		return make_result(lo, 1'b0);
	endfunction

	// window over: finish, or fall back to the full sweep when it found nothing and the policy allows
	function automatic out_t window_or_fallback();
		if (best_hit == 8'd0 && (!policy_q || start_code != 8'd0))
			return open_sweep(SRCH_FULL, 8'd0, CODE_MAX);
		phase_q = SRCH_IDLE;
		return make_result(best_hit, 1'b1);
	endfunction

	function automatic out_t predict_search_step(input in_t item);
		logic       hit;
		logic [7:0] trial;
		int         lo;
		int         hi;
		if (item.action == ACT_START) begin
			phase_q = SRCH_SAR;
			bit_pos = 3'd7;
			approx  = 8'd0;
			return make_result(8'h80, 1'b0);
		end
		hit = item.readout_word[col_sel];
		case (phase_q)
			SRCH_SAR: begin
				trial = approx | (8'd1 << bit_pos);
				if (hit)
					approx = trial;
				if (bit_pos != 3'd0) begin
					bit_pos--;
					return make_result(approx | (8'd1 << bit_pos), 1'b0);
				end
				bit_pos    = 3'd7;
				start_code = approx;
				lo = (start_code > half_width) ? int'(start_code) - int'(half_width) : 0;
				hi = int'(start_code) + int'(half_width);
				if (hi > int'(CODE_MAX))
					hi = int'(CODE_MAX);
				if (lo < hi)
					return open_sweep(SRCH_WINDOW, 8'(lo), 8'(hi));
				// empty window counts as no hit
				best_hit = 8'd0;
				return window_or_fallback();
			end
			SRCH_WINDOW, SRCH_FULL: begin
				if (hit)
					best_hit = sweep_at;
				sweep_at++;
				if (sweep_at < sweep_end)
					return make_result(sweep_at, 1'b0);
				if (phase_q == SRCH_WINDOW)
					return window_or_fallback();
				phase_q = SRCH_IDLE;
				return make_result(best_hit, 1'b1);
			end
			default: return make_result(best_hit, 1'b1);
		endcase
	endfunction

	function automatic in_t start_item();
		in_t it;
		it.action       = ACT_START;
		it.readout_word = $urandom;
		return it;
	endfunction

	function automatic in_t readout_item(input logic hit);
		in_t it;
		it.action                = ACT_READOUT;
		it.readout_word          = $urandom;
		it.readout_word[col_sel] = hit;
		return it;
	endfunction

	task automatic send_item(input in_t item, output out_t predicted);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		predicted = predict_search_step(item);
		expected_results.push_back(predicted);
		items_sent++;
	endtask

	// registers change only with the block idle and nothing outstanding
	task automatic apply_settings(input logic [COL_W-1:0] col, input logic [7:0] half,
			input logic policy);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_COLUMN_SELECT;
		cfg_data  <= CFG_DATA_W'(col);
		@(posedge clk);
		cfg_index <= REG_WINDOW_HALF;
		cfg_data  <= half;
		@(posedge clk);
		cfg_index <= REG_FALLBACK_POLICY;
		cfg_data  <= CFG_DATA_W'(policy);
		@(posedge clk);
		cfg_we     <= 1'b0;
		col_sel    = col;
		half_width = half;
		policy_q   = policy;
	endtask

	// one search from start to final code, comparator bit chosen by mode
	task automatic run_search(input hit_mode_t mode, input logic [7:0] target);
		out_t last;
		logic hit;
		send_item(start_item(), last);
		while (!last.done_res) begin
			if ($urandom_range(0, 79) == 0) begin
				// abandon the running search and begin again
				send_item(start_item(), last);
				continue;
			end
			case (mode)
				HITS_BELOW_TARGET: hit = (last.code <= target);
				HITS_RANDOM:       hit = 1'($urandom_range(0, 1));
				default:           hit = 1'b0;
			endcase
			send_item(readout_item(hit), last);
		end
	endtask

	task automatic test_idle_readout();
		out_t last;
		in_t  it;
		it.action       = ACT_READOUT;
		it.readout_word = '1;
		send_item(it, last);
		it.readout_word = '0;
		send_item(it, last);
	endtask

	task automatic test_empty_window();
		apply_settings(5'd31, 8'd0, 1'b1);
		run_search(HITS_NONE, 8'd0);
	endtask

	task automatic test_restart();
		out_t last;
		apply_settings(5'd0, 8'd1, 1'b0);
		send_item(start_item(), last);
		repeat (3) send_item(readout_item(1'($urandom_range(0, 1))), last);
		run_search(HITS_BELOW_TARGET, 8'd255);
	endtask

	task automatic test_random_searches();
		int               phase_no;
		int               pick;
		int               searches;
		logic [COL_W-1:0] col;
		logic [7:0]       half;
		logic             policy;
		logic [7:0]       target;
		hit_mode_t        mode;
		in_t              noise;
		out_t             last;
		phase_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase_no)
				0: begin col = 5'd31; half = 8'd128; policy = 1'b1; end
				1: begin col = 5'd0;  half = 8'd255; policy = 1'b0; end
				2: begin col = 5'd17; half = 8'd1;   policy = 1'b0; end
				default: begin
					col    = COL_W'($urandom_range(0, 31));
					policy = 1'($urandom_range(0, 1));
					pick   = $urandom_range(0, 19);
					case (pick)
						0:       half = 8'd0;
						1:       half = 8'd128;
						2:       half = 8'd255;
						3:       half = 8'd1;
						default: half = 8'($urandom_range(1, 12));
					endcase
				end
			endcase
			apply_settings(col, half, policy);
			gaps_on  = ($urandom_range(0, 3) != 0);
			searches = (half == 8'd0 || half > 8'd64) ? 1 : $urandom_range(1, 4);
			repeat (searches) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 6)) begin
						noise.action       = 1'($urandom_range(0, 1));
						noise.readout_word = $urandom;
						send_item(noise, last);
					end
				end
				pick = $urandom_range(0, 15);
				if (pick == 0)
					mode = HITS_NONE;
				else if (pick < 4)
					mode = HITS_RANDOM;
				else
					mode = HITS_BELOW_TARGET;
				target = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
				run_search(mode, target);
			end
			phase_no++;
		end
	endtask

	task automatic test_steady_stream();
		hit_mode_t mode;
		gaps_on = 1'b0;
		apply_settings(COL_W'($urandom_range(0, 31)), 8'($urandom_range(1, 8)),
			1'($urandom_range(0, 1)));
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				mode = HITS_RANDOM;
			else
				mode = HITS_BELOW_TARGET;
			run_search(mode, 8'($urandom_range(1, 255)));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: code %0d done_res %0d",
					out_data.code, out_data.done_res);
				failures++;
			end else begin
				oldest = expected_results.pop_front();
				if (out_data.code !== oldest.code) begin
					$error("code: expected %0d, actual %0d", oldest.code, out_data.code);
					failures++;
				end
				if (out_data.done_res !== oldest.done_res) begin
					$error("done_res: expected %0d, actual %0d", oldest.done_res,
						out_data.done_res);
					failures++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("sar_search_with_window_refine_top_test NOT OK");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_COLUMN_SELECT;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		stuck_cycles = 0;
		items_sent = 0;
		failures   = 0;
		gaps_on    = 1'b1;
		phase_q    = SRCH_IDLE;
		bit_pos    = 3'd7;
		approx     = 8'd0;
		start_code = 8'd0;
		sweep_at   = 8'd0;
		sweep_end  = 8'd0;
		best_hit   = 8'd0;
		col_sel    = '0;
		half_width = 8'd8;
		policy_q   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_readout();
		test_empty_window();
		test_restart();
		test_random_searches();
		test_steady_stream();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("sar_search_with_window_refine_top_test OK");
		else
			$display("sar_search_with_window_refine_top_test NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
src/sswr_pkg.sv
src/sar_search_with_window_refine_top.sv
tb/sar_search_with_window_refine_top_test.sv
